FILE: src/rws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selection package
// Field widths, default sizes and the function and status codes shared by
// the interfaces, the top level and the checker.
// ----------------------------------------------------------------------------
package rws_pkg;

  // Default sizes of the population store.
  localparam int POPULATION_DEPTH_DEF = 256;
  localparam int FITNESS_BITS_DEF     = 16;

  // Widths of the fields on the channels.
  localparam int FUNC_W     = 2;
  localparam int FIT_W      = 16;
  localparam int FRAC_W     = 32;
  localparam int SEL_W      = 8;
  localparam int BEST_W     = 8;
  localparam int CNT_OUT_W  = 9;
  localparam int TOT_OUT_W  = 24;
  localparam int STATUS_W   = 2;

  // The scaling multiplier retires one bit of the random fraction per cycle.
  localparam int STEP_W = $clog2(FRAC_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SELECT = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

endpackage

FILE: src/rws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selection channels
// Valid/ready interfaces for the request words and the result words.
// ----------------------------------------------------------------------------
interface rws_in_if;
  logic                         valid;
  logic                         ready;
  logic [rws_pkg::FUNC_W-1:0]   func;
  logic [rws_pkg::FIT_W-1:0]    fitness_value;
  logic [rws_pkg::FRAC_W-1:0]   random_fraction;

  modport source (output valid, output func, output fitness_value,
                  output random_fraction, input ready);
  modport sink   (input valid, input func, input fitness_value,
                  input random_fraction, output ready);
endinterface

interface rws_out_if;
  logic                           valid;
  logic                           ready;
  logic [rws_pkg::SEL_W-1:0]      selected_index;
  logic [rws_pkg::BEST_W-1:0]     best_index;
  logic [rws_pkg::CNT_OUT_W-1:0]  population_count;
  logic [rws_pkg::TOT_OUT_W-1:0]  fitness_total;
  logic [rws_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output selected_index, output best_index,
                  output population_count, output fitness_total, output status,
                  input ready);
  modport sink   (input valid, input selected_index, input best_index,
                  input population_count, input fitness_total, input status,
                  output ready);
endinterface

FILE: src/rws_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fitness store
// Single-port-write, single-port-read synchronous memory with registered
// read data.
// ----------------------------------------------------------------------------
module rws_mem #(
  parameter int DEPTH = rws_pkg::POPULATION_DEPTH_DEF,
  parameter int WIDTH = rws_pkg::FITNESS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/roulette_wheel_selection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selection
// Fitness-proportionate parent selection over a stored population.
// ----------------------------------------------------------------------------
// The block keeps a population of fitness values in an on-chip memory and
// handles one request word at a time: clear, append a fitness, or select a
// parent. Every request returns exactly one result word carrying the selected
// index, the best index, the population count and the fitness total. Clear
// and append go from acceptance to the done state, which loads the output
// register once it is free, and the next request word is taken after that.
// A select first scales the random fraction by the total with a shift-and-add
// multiplier that retires one fraction bit per cycle, then walks the memory
// one entry per cycle, accumulating fitness until the running sum reaches the
// target. Each checked entry passes through the registered read address and
// the memory's registered read data; the select then goes to the done state,
// which loads the output register once it is free. The memory read port sets
// the walk rate. A new request word is taken as soon as the previous one has
// finished, even while its result is still waiting in the output register.
// The memory needs no clearing after reset, since only entries below the
// current count are ever read.
// ----------------------------------------------------------------------------
module roulette_wheel_selection_top #(
  parameter int POPULATION_DEPTH = rws_pkg::POPULATION_DEPTH_DEF,
  parameter int FITNESS_BITS     = rws_pkg::FITNESS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rws_in_if.sink    in_ch,
  rws_out_if.source out_ch
);

  import rws_pkg::*;

  localparam int IDX_W  = $clog2(POPULATION_DEPTH);
  localparam int CNT_W  = $clog2(POPULATION_DEPTH + 1);
  // The total of a full store of maximal entries fits in this width.
  localparam int TOT_W  = FITNESS_BITS + IDX_W;
  localparam int PROD_W = TOT_W + FRAC_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POPULATION_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Control state.
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TOT_W-1:0]      tot_r, tot_nxt;
  logic [FITNESS_BITS-1:0] best_fit_r, best_fit_nxt;
  logic [IDX_W-1:0]      best_pos_r, best_pos_nxt;
  logic [STEP_W-1:0]     mstep_r, mstep_nxt;
  logic [CNT_W-1:0]      rd_addr_r, rd_addr_nxt;
  logic                  pv_r, pv_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [TOT_W-1:0]      cum_r, cum_nxt;
  logic [IDX_W-1:0]      pidx_r, pidx_nxt;
  logic [IDX_W-1:0]      res_sel_r, res_sel_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [SEL_W-1:0]      out_sel_r, out_sel_nxt;
  logic [BEST_W-1:0]     out_best_r, out_best_nxt;
  logic [CNT_OUT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [TOT_OUT_W-1:0]  out_tot_r, out_tot_nxt;
  status_t               out_status_r, out_status_nxt;

  // Memory port and helpers.
  logic                    accept;
  logic                    mem_we;
  logic [FITNESS_BITS-1:0] rd_data;
  logic [FITNESS_BITS-1:0] fit_in;
  logic [47:0]             fit_ext;
  logic [TOT_W:0]          mul_add;
  logic [TOT_W-1:0]        target;
  logic [TOT_W-1:0]        cum_sum;
  logic                    last_entry;
  logic [31:0]             sel_ext;
  logic [31:0]             best_ext;
  logic [31:0]             cnt_ext;
  logic [63:0]             tot_ext;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Only the low FITNESS_BITS bits of the offered fitness are kept.
  assign fit_ext = 48'(in_ch.fitness_value);
  assign fit_in  = fit_ext[FITNESS_BITS-1:0];

  // The store only ever appends at the current count, and it is never read
  // in the same item that writes it, so no forwarding is needed.
  assign mem_we = accept && (func_t'(in_ch.func) == FUNC_APPEND) && (cnt_r != FULL_CNT);

  rws_mem #(
    .DEPTH (POPULATION_DEPTH),
    .WIDTH (FITNESS_BITS)
  ) u_rws_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (fit_in),
    .rd_addr (rd_addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // One shift-and-add step of fraction times total: the upper TOT_W bits of the
  // product register take the partial sum, the lower FRAC_W bits shift out the
  // multiplier bits. After all steps the upper TOT_W bits are the scaled target.
  assign mul_add = {1'b0, prod_r[PROD_W-1:FRAC_W]} + (prod_r[0] ? {1'b0, tot_r} : '0);
  assign target  = prod_r[PROD_W-1:FRAC_W];

  assign cum_sum    = cum_r + TOT_W'(rd_data);
  assign last_entry = ((CNT_W'(pidx_r) + CNT_W'(1)) == cnt_r);

  // Output fields carry the low bits of the wider internal values.
  assign sel_ext  = 32'(res_sel_r);
  assign best_ext = 32'(best_pos_r);
  assign cnt_ext  = 32'(cnt_r);
  assign tot_ext  = 64'(tot_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    tot_nxt        = tot_r;
    best_fit_nxt   = best_fit_r;
    best_pos_nxt   = best_pos_r;
    mstep_nxt      = mstep_r;
    rd_addr_nxt    = rd_addr_r;
    pv_nxt         = pv_r;
    out_valid_nxt  = out_valid_r;
    prod_nxt       = prod_r;
    cum_nxt        = cum_r;
    pidx_nxt       = pidx_r;
    res_sel_nxt    = res_sel_r;
    res_status_nxt = res_status_r;
    out_sel_nxt    = out_sel_r;
    out_best_nxt   = out_best_r;
    out_cnt_nxt    = out_cnt_r;
    out_tot_nxt    = out_tot_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_sel_nxt    = '0;
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_DONE;
          case (func_t'(in_ch.func))
            FUNC_CLEAR: begin
              cnt_nxt      = '0;
              tot_nxt      = '0;
              best_fit_nxt = '0;
              best_pos_nxt = '0;
            end
            FUNC_APPEND: begin
              if (cnt_r == FULL_CNT) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                // The first entry always becomes best; later ones only on a
                // strictly greater fitness, so the earlier entry wins ties.
                if ((cnt_r == '0) || (fit_in > best_fit_r)) begin
                  best_fit_nxt = fit_in;
                  best_pos_nxt = cnt_r[IDX_W-1:0];
                end
                cnt_nxt = cnt_r + CNT_W'(1);
                tot_nxt = tot_r + TOT_W'(fit_in);
              end
            end
            FUNC_SELECT: begin
              if (cnt_r == '0) begin
                res_status_nxt = STATUS_EMPTY;
              end else begin
                prod_nxt  = PROD_W'(in_ch.random_fraction);
                mstep_nxt = '0;
                state_nxt = ST_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_MUL: begin
        prod_nxt  = {mul_add, prod_r[FRAC_W-1:1]};
        mstep_nxt = mstep_r + STEP_W'(1);
        if (mstep_r == STEP_W'(FRAC_W - 1)) begin
          rd_addr_nxt = '0;
          pv_nxt      = 1'b0;
          cum_nxt     = '0;
          state_nxt   = ST_WALK;
        end
      end

      ST_WALK: begin
        // Issue the next read while the previous entry's data is checked.
        if (rd_addr_r < cnt_r) begin
          rd_addr_nxt = rd_addr_r + CNT_W'(1);
          pv_nxt      = 1'b1;
          pidx_nxt    = rd_addr_r[IDX_W-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (cum_sum >= target) begin
            res_sel_nxt = pidx_r;
            pv_nxt      = 1'b0;
            state_nxt   = ST_DONE;
          end else begin
            cum_nxt = cum_sum;
            if (last_entry) begin
              res_sel_nxt = '0;
              pv_nxt      = 1'b0;
              state_nxt   = ST_DONE;
            end
          end
        end
      end

      ST_DONE: begin
        // Wait for the output register to be free, then hand the word over.
        if (!out_valid_r || out_ch.ready) begin
          out_sel_nxt    = sel_ext[SEL_W-1:0];
          out_best_nxt   = best_ext[BEST_W-1:0];
          out_cnt_nxt    = cnt_ext[CNT_OUT_W-1:0];
          out_tot_nxt    = tot_ext[TOT_OUT_W-1:0];
          out_status_nxt = res_status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      tot_r       <= '0;
      best_fit_r  <= '0;
      best_pos_r  <= '0;
      mstep_r     <= '0;
      rd_addr_r   <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tot_r       <= tot_nxt;
      best_fit_r  <= best_fit_nxt;
      best_pos_r  <= best_pos_nxt;
      mstep_r     <= mstep_nxt;
      rd_addr_r   <= rd_addr_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    cum_r        <= cum_nxt;
    pidx_r       <= pidx_nxt;
    res_sel_r    <= res_sel_nxt;
    res_status_r <= res_status_nxt;
    out_sel_r    <= out_sel_nxt;
    out_best_r   <= out_best_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_tot_r    <= out_tot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.selected_index   = out_sel_r;
  assign out_ch.best_index       = out_best_r;
  assign out_ch.population_count = out_cnt_r;
  assign out_ch.fitness_total    = out_tot_r;
  assign out_ch.status           = out_status_r;

endmodule

FILE: src/rws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selection checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rws_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rws_pkg::SEL_W-1:0]      out_selected_index,
  input logic [rws_pkg::CNT_OUT_W-1:0]  out_population_count,
  input logic [rws_pkg::TOT_OUT_W-1:0]  out_fitness_total,
  input logic [rws_pkg::STATUS_W-1:0]   out_status
);

  import rws_pkg::*;

  // A stalled result word stays offered, with its selected index, status and fitness total unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_selected_index)
      && $stable(out_status) && $stable(out_fitness_total))
    else $error("result word changed while stalled");

  // A select on an empty store reports no selection and an empty count.
  a_empty_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_EMPTY) |->
      (out_selected_index == '0) && (out_population_count == '0))
    else $error("empty-store select reported a selection or a count");

  // A refused append never carries a selected index.
  a_full_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_FULL) |-> (out_selected_index == '0))
    else $error("refused append carried a selected index");

  // The status code is always one of the defined outcomes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK) || (out_status == STATUS_FULL)
      || (out_status == STATUS_EMPTY))
    else $error("undefined status code on the result channel");

endmodule

bind roulette_wheel_selection_top rws_checker u_rws_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_selected_index   (out_ch.selected_index),
  .out_population_count (out_ch.population_count),
  .out_fitness_total    (out_ch.fitness_total),
  .out_status           (out_ch.status)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selection testbench
// Sends clear, append, select and unused request words to the block with
// random gaps and result stalls. A scoreboard keeps its own copy of the
// population, works out the expected result word for each accepted request,
// and checks every result word field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import rws_pkg::*;

  localparam int                DEPTH       = POPULATION_DEPTH_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int                WORD_TARGET = 1670;

  // One result word as the block should present it.
  typedef struct packed {
    logic [SEL_W-1:0]     sel;
    logic [BEST_W-1:0]    best;
    logic [CNT_OUT_W-1:0] count;
    logic [TOT_OUT_W-1:0] total;
    status_t              status;
  } wheel_result_t;

  // The scoreboard mirrors the population store and queues the result word
  // that each accepted request should produce.
  class wheel_scoreboard;
    logic [FIT_W-1:0]     wheel [DEPTH];
    int unsigned          count;
    logic [TOT_OUT_W-1:0] total;
    logic [FIT_W-1:0]     best_fit;
    logic [BEST_W-1:0]    best_pos;
    wheel_result_t        awaited [$];
    int                   errors;

    function new();
      count    = 0;
      total    = '0;
      best_fit = '0;
      best_pos = '0;
      errors   = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Applies one accepted request to the mirrored population.
    function void note_request(logic [FUNC_W-1:0] func, logic [FIT_W-1:0] fit,
                               logic [FRAC_W-1:0] frac);
      wheel_result_t r;
      logic [55:0]   product;
      logic [23:0]   target;
      logic [24:0]   cum;
      bit            found;
      r        = '0;
      r.status = STATUS_OK;
      case (func)
        FUNC_CLEAR: begin
          count    = 0;
          total    = '0;
          best_fit = '0;
          best_pos = '0;
        end
        FUNC_APPEND: begin
          if (count >= DEPTH) begin
            r.status = STATUS_FULL;
          end else begin
            // The first entry is always best; later ones only on a strict win.
            if (count == 0 || fit > best_fit) begin
              best_fit = fit;
              best_pos = count[BEST_W-1:0];
            end
            wheel[count] = fit;
            count++;
            total = total + fit;
          end
        end
        FUNC_SELECT: begin
          if (count == 0) begin
            r.status = STATUS_EMPTY;
          end else begin
            // The target is the fraction scaled by the total, floored.
            product = {24'd0, frac} * {32'd0, total};
            target  = product[55:32];
            cum     = '0;
            found   = 1'b0;
            for (int i = 0; i < count; i++) begin
              cum = cum + wheel[i];
              if (!found && cum >= target) begin
                r.sel = i[SEL_W-1:0];
                found = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
      r.best  = best_pos;
      r.count = count[CNT_OUT_W-1:0];
      r.total = total;
      awaited = {awaited, r};
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(wheel_result_t act);
      wheel_result_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: result word with nothing outstanding, expected none, actual %h",
                 $time, act);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      compare_field("selected_index", exp.sel, act.sel);
      compare_field("best_index", exp.best, act.best);
      compare_field("population_count", exp.count, act.count);
      compare_field("fitness_total", exp.total, act.total);
      compare_field("status", exp.status, act.status);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rws_in_if  in_ch ();
  rws_out_if out_ch ();

  roulette_wheel_selection_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wheel_scoreboard board = new();

  int words_sent;
  bit sender_calm;
  bit recv_calm;
  bit drain_req;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Fitness values lean towards zero, the maximum and small numbers, so that
  // ties, zero-fitness entries and zero totals come up often.
  function automatic logic [FIT_W-1:0] pick_fitness();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return FIT_W'($urandom_range(1, 15));
      default: return FIT_W'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] pick_fraction();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Presents one request word and holds it until the block takes it. Valid
  // is only dropped when a gap or a drain is wanted, and then the gap is
  // never empty, so valid never sees two assignments in one time step.
  task automatic send_word(logic [FUNC_W-1:0] func, logic [FIT_W-1:0] fit,
                           logic [FRAC_W-1:0] frac);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0 || drain_req) begin
      in_ch.valid <= 1'b0;
      if (gap == 0) gap = 1;
      repeat (gap) @(posedge clk);
      while (drain_req && board.pending() != 0) @(posedge clk);
      drain_req = 1'b0;
    end
    in_ch.valid           <= 1'b1;
    in_ch.func            <= func;
    in_ch.fitness_value   <= fit;
    in_ch.random_fraction <= frac;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(func, fit, frac);
    words_sent++;
  endtask

  // Result side: a random stall before each word, with calm stretches in
  // which ready stays high throughout.
  initial begin
    int stall;
    recv_calm = 1'b0;
    forever begin
      if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_ch.valid === 1'b1));
      board.check_result('{out_ch.selected_index, out_ch.best_index,
                           out_ch.population_count, out_ch.fitness_total,
                           status_t'(out_ch.status)});
    end
  end

  // Hard limit, set well above the slowest correct run of full-store selects
  // with the longest gaps and stalls on every word.
  initial begin
    #25_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int n_append;
    int n_select;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.func            <= FUNC_CLEAR;
    in_ch.fitness_value   <= '0;
    in_ch.random_fraction <= '0;
    words_sent  = 0;
    sender_calm = 1'b0;
    drain_req   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. An empty store must refuse a select; the unused code
    // must leave everything alone; a zero-fitness first entry still becomes
    // best; a zero total must pick index 0; equal maxima keep the earlier one.
    send_word(FUNC_SELECT, '0, '1);
    send_word(FUNC_UNUSED, '1, '1);
    send_word(FUNC_APPEND, '0, '0);
    send_word(FUNC_SELECT, '0, '1);
    send_word(FUNC_APPEND, '0, '0);
    send_word(FUNC_SELECT, '0, 32'h8000_0000);
    send_word(FUNC_APPEND, 16'hFFFF, '0);
    send_word(FUNC_APPEND, 16'hFFFF, '0);
    send_word(FUNC_APPEND, 16'h0001, '0);
    send_word(FUNC_APPEND, 16'h5555, '0);
    send_word(FUNC_APPEND, 16'hAAAA, '0);
    send_word(FUNC_SELECT, '0, '0);
    send_word(FUNC_SELECT, '0, '1);
    send_word(FUNC_SELECT, '0, 32'h8000_0000);
    send_word(FUNC_SELECT, '0, 32'h5555_5555);
    send_word(FUNC_UNUSED, 16'h5555, 32'hAAAA_AAAA);
    send_word(FUNC_CLEAR, '1, '1);
    send_word(FUNC_SELECT, '0, 32'h1234_5678);
    send_word(FUNC_APPEND, 16'h1234, '0);
    send_word(FUNC_SELECT, '0, '1);
    send_word(FUNC_CLEAR, '0, '0);

    // Let the block run dry once before the random part begins.
    drain_req = 1'b1;

    // Random part. Most of it is a clear followed by a population and a
    // handful of selects; now and then the store is filled to the brim and
    // overfilled, and the rest is loose noise with every function code.
    while (words_sent < WORD_TARGET) begin
      sender_calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 39) == 0) drain_req = 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        send_word(FUNC_CLEAR, FIT_W'($urandom), $urandom);
        case ($urandom_range(0, 49))
          0:       n_append = DEPTH + $urandom_range(1, 3);
          1, 2, 3: n_append = $urandom_range(13, 60);
          default: n_append = $urandom_range(1, 12);
        endcase
        for (int i = 0; i < n_append; i++) begin
          send_word(FUNC_APPEND, pick_fitness(), $urandom);
        end
        n_select = $urandom_range(1, 8);
        for (int i = 0; i < n_select; i++) begin
          // An odd append between selects shifts the wheel under them.
          if ($urandom_range(0, 7) == 0) send_word(FUNC_APPEND, pick_fitness(), $urandom);
          send_word(FUNC_SELECT, FIT_W'($urandom), pick_fraction());
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_word(FUNC_W'($urandom_range(0, 3)), pick_fitness(), pick_fraction());
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Wait for every result, then a little longer to catch strays.
    while (board.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: roulette_wheel_selection_top.f
src/rws_pkg.sv
src/rws_if.sv
src/rws_mem.sv
src/roulette_wheel_selection_top.sv
src/rws_checker.sv
test/testbench.sv
